FILE: rtl/mior_pkg.sv
// Shared types, constants and register decode table for the masked I/O register file.
`default_nettype none

package mior_pkg;

    // Field widths
    localparam int CMD_W  = 3;
    localparam int ADDR_W = 16;
    localparam int DATA_W = 8;
    localparam int CODE_W = 3;

    // Bank geometry
    localparam int STORE_DEPTH  = 128;
    localparam int DECODE_SPAN  = 81;
    localparam int NUM_SLOTS    = 26;
    localparam int SLOT_W       = $clog2(NUM_SLOTS);
    localparam int DECODE_LIMIT_I = (DECODE_SPAN < STORE_DEPTH) ? DECODE_SPAN : STORE_DEPTH;
    localparam logic [ADDR_W:0]   DECODE_LIMIT = (ADDR_W + 1)'(DECODE_LIMIT_I);
    localparam logic [ADDR_W-1:0] BASE_ADDRESS = 16'hFF00;

    // Commands
    localparam logic [CMD_W-1:0] CMD_IO_READ     = 3'd0;
    localparam logic [CMD_W-1:0] CMD_IO_WRITE    = 3'd1;
    localparam logic [CMD_W-1:0] CMD_AUDIO_READ  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_AUDIO_WRITE = 3'd3;
    localparam logic [CMD_W-1:0] CMD_VIDEO_READ  = 3'd4;
    localparam logic [CMD_W-1:0] CMD_VIDEO_WRITE = 3'd5;

    // Fault codes
    localparam logic [CODE_W-1:0] FAULT_NONE        = 3'd0;
    localparam logic [CODE_W-1:0] FAULT_IO_READ     = 3'd1;
    localparam logic [CODE_W-1:0] FAULT_IO_WRITE    = 3'd2;
    localparam logic [CODE_W-1:0] FAULT_AUDIO_READ  = 3'd3;
    localparam logic [CODE_W-1:0] FAULT_AUDIO_WRITE = 3'd4;
    localparam logic [CODE_W-1:0] FAULT_VIDEO_READ  = 3'd5;
    localparam logic [CODE_W-1:0] FAULT_VIDEO_WRITE = 3'd6;

    // Port membership bits
    localparam logic [2:0] PORT_NONE  = 3'b000;
    localparam logic [2:0] PORT_IO    = 3'b001;
    localparam logic [2:0] PORT_AUDIO = 3'b010;
    localparam logic [2:0] PORT_VIDEO = 3'b100;

    typedef struct packed {
        logic [2:0]        ports;
        logic [DATA_W-1:0] rmask;
        logic [DATA_W-1:0] wmask;
        logic [SLOT_W-1:0] slot;
    } desc_t;

    // Decoded access handed to the register bank
    typedef struct packed {
        logic              hit;
        logic              is_write;
        logic [SLOT_W-1:0] slot;
        logic [DATA_W-1:0] rmask;
        logic [DATA_W-1:0] wmask;
        logic [CODE_W-1:0] fault;
    } acc_t;

    // Stored power-on contents per slot (already through the CPU write mask)
    localparam logic [DATA_W-1:0] SLOT_RESET [NUM_SLOTS] = '{
        8'h00, 8'hBF, 8'hF3, 8'hF3, 8'h0F, 8'h3F, 8'h00, 8'hFF, 8'h0F,
        8'h00, 8'hFF, 8'h00, 8'hFF, 8'h0F, 8'h3F, 8'h00, 8'h00, 8'h00,
        8'h77, 8'hF3, 8'h80, 8'h91, 8'h00, 8'h00, 8'hFC, 8'h00
    };

    function automatic desc_t reg_desc(input logic [6:0] off);
        desc_t d;
        d = '{ports: PORT_NONE, rmask: 8'h00, wmask: 8'h00, slot: '0};
        unique case (off)
            7'h10: d = '{PORT_IO | PORT_AUDIO, 8'h80, 8'h7F, SLOT_W'(0)};
            7'h11: d = '{PORT_IO | PORT_AUDIO, 8'h3F, 8'hFF, SLOT_W'(1)};
            7'h12: d = '{PORT_IO | PORT_AUDIO, 8'h00, 8'hFF, SLOT_W'(2)};
            7'h13: d = '{PORT_IO | PORT_AUDIO, 8'hFF, 8'hFF, SLOT_W'(3)};
            7'h14: d = '{PORT_IO | PORT_AUDIO, 8'hBF, 8'hCF, SLOT_W'(4)};
            7'h16: d = '{PORT_IO | PORT_AUDIO, 8'h3F, 8'hFF, SLOT_W'(5)};
            7'h17: d = '{PORT_IO | PORT_AUDIO, 8'h00, 8'hFF, SLOT_W'(6)};
            7'h18: d = '{PORT_IO | PORT_AUDIO, 8'hFF, 8'hFF, SLOT_W'(7)};
            7'h19: d = '{PORT_IO | PORT_AUDIO, 8'hBF, 8'hCF, SLOT_W'(8)};
            7'h1A: d = '{PORT_IO | PORT_AUDIO, 8'h7F, 8'h80, SLOT_W'(9)};
            7'h1B: d = '{PORT_IO | PORT_AUDIO, 8'h00, 8'hFF, SLOT_W'(10)};
            7'h1C: d = '{PORT_IO | PORT_AUDIO, 8'h9F, 8'h60, SLOT_W'(11)};
            7'h1D: d = '{PORT_IO | PORT_AUDIO, 8'h00, 8'hFF, SLOT_W'(12)};
            7'h1E: d = '{PORT_IO | PORT_AUDIO, 8'hBF, 8'hCF, SLOT_W'(13)};
            7'h20: d = '{PORT_IO | PORT_AUDIO, 8'hFF, 8'h3F, SLOT_W'(14)};
            7'h21: d = '{PORT_IO | PORT_AUDIO, 8'h00, 8'hFF, SLOT_W'(15)};
            7'h22: d = '{PORT_IO | PORT_AUDIO, 8'h00, 8'hFF, SLOT_W'(16)};
            7'h23: d = '{PORT_IO | PORT_AUDIO, 8'hBF, 8'hC0, SLOT_W'(17)};
            7'h24: d = '{PORT_IO | PORT_AUDIO, 8'h00, 8'hFF, SLOT_W'(18)};
            7'h25: d = '{PORT_IO | PORT_AUDIO, 8'h00, 8'hFF, SLOT_W'(19)};
            7'h26: d = '{PORT_IO | PORT_AUDIO, 8'h70, 8'h80, SLOT_W'(20)};
            7'h40: d = '{PORT_IO | PORT_VIDEO, 8'h00, 8'hFF, SLOT_W'(21)};
            7'h42: d = '{PORT_IO | PORT_VIDEO, 8'h00, 8'hFF, SLOT_W'(22)};
            7'h44: d = '{PORT_IO | PORT_VIDEO, 8'h00, 8'h00, SLOT_W'(23)};
            7'h47: d = '{PORT_IO | PORT_VIDEO, 8'h00, 8'hFF, SLOT_W'(24)};
            7'h50: d = '{PORT_IO,              8'h00, 8'h01, SLOT_W'(25)};
            default: d = '{ports: PORT_NONE, rmask: 8'h00, wmask: 8'h00, slot: '0};
        endcase
        return d;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/mior_req_if.sv
// Access request channel: command, address and write byte.
`default_nettype none

interface mior_req_if
    import mior_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  command;
    logic [ADDR_W-1:0] address;
    logic [DATA_W-1:0] write_value;

    modport source (output valid, output command, output address, output write_value,
                    input ready);
    modport sink   (input valid, input command, input address, input write_value,
                    output ready);
endinterface

`default_nettype wire

FILE: rtl/mior_rsp_if.sv
// Access response channel: read byte and fault codes.
`default_nettype none

interface mior_rsp_if
    import mior_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] read_data;
    logic [CODE_W-1:0] access_fault;
    logic [CODE_W-1:0] sticky_fault;

    modport source (output valid, output read_data, output access_fault,
                    output sticky_fault, input ready);
    modport sink   (input valid, input read_data, input access_fault,
                    input sticky_fault, output ready);
endinterface

`default_nettype wire

FILE: rtl/mior_decode.sv
// Address and command decode: register slot, port-adjusted masks and fault code.
`default_nettype none

module mior_decode
    import mior_pkg::*;
(
    input  wire logic [CMD_W-1:0]  command,
    input  wire logic [ADDR_W-1:0] address,
    output acc_t                   acc
);

    logic [ADDR_W-1:0] off;
    logic              in_range;
    desc_t             desc;
    logic [2:0]        port;
    logic [CODE_W-1:0] code;
    logic              is_write;
    logic              hit;

    assign off      = address - BASE_ADDRESS;
    assign in_range = (address >= BASE_ADDRESS) && ({1'b0, off} < DECODE_LIMIT);
    assign desc     = reg_desc(off[6:0]);

    always_comb
    begin
        port     = PORT_NONE;
        code     = FAULT_NONE;
        is_write = 1'b0;
        unique case (command)
            CMD_IO_READ:     begin port = PORT_IO;    code = FAULT_IO_READ;     end
            CMD_IO_WRITE:    begin port = PORT_IO;    code = FAULT_IO_WRITE;
                                   is_write = 1'b1;                             end
            CMD_AUDIO_READ:  begin port = PORT_AUDIO; code = FAULT_AUDIO_READ;  end
            CMD_AUDIO_WRITE: begin port = PORT_AUDIO; code = FAULT_AUDIO_WRITE;
                                   is_write = 1'b1;                             end
            CMD_VIDEO_READ:  begin port = PORT_VIDEO; code = FAULT_VIDEO_READ;  end
            CMD_VIDEO_WRITE: begin port = PORT_VIDEO; code = FAULT_VIDEO_WRITE;
                                   is_write = 1'b1;                             end
            default:         begin port = PORT_NONE;  code = FAULT_NONE;        end
        endcase
    end

    assign hit = in_range && ((desc.ports & port) != PORT_NONE);

    always_comb
    begin
        acc.hit      = hit;
        acc.is_write = is_write;
        acc.slot     = desc.slot;
        // audio and video ports see the bank unmasked
        acc.rmask    = (port == PORT_IO) ? desc.rmask : 8'h00;
        acc.wmask    = (port == PORT_IO) ? desc.wmask : 8'hFF;
        acc.fault    = (port != PORT_NONE && !hit) ? code : FAULT_NONE;
    end

endmodule

`default_nettype wire

FILE: rtl/mior_regs.sv
// Register bank: one byte per decoded register, masked read and write.
`default_nettype none

module mior_regs
    import mior_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              en,
    input  wire acc_t              acc,
    input  wire logic [DATA_W-1:0] write_value,
    output logic [DATA_W-1:0]      read_data
);

    logic [DATA_W-1:0] store_reg [NUM_SLOTS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_SLOTS; i++)
            begin
                store_reg[i] <= SLOT_RESET[i];
            end
        end
        else if (en && acc.hit && acc.is_write)
        begin
            store_reg[acc.slot] <= write_value & acc.wmask;
        end
    end

    assign read_data = (acc.hit && !acc.is_write) ? (store_reg[acc.slot] | acc.rmask)
                                                  : 8'h00;

endmodule

`default_nettype wire

FILE: rtl/masked_io_register_file.sv
// Masked I/O register file for sound, LCD and boot mapping registers.
//
// Usage: each beat on req carries one access (command, address, write_value);
// each access yields exactly one beat on rsp (read_data, access_fault,
// sticky_fault), in order. CPU reads OR in a per-register read mask, CPU
// writes AND with a write mask; audio and video ports access their own
// subsets unmasked. A bad address returns 0 and records its fault code.
// An accepted request is held in the input register and decoded from it;
// its response is registered in the output register.
// Throughput: one access per cycle while rsp is ready, set by the single
// decode and bank access between the input and output registers.
// Reset: the bank loads its power-on values, the sticky fault clears and
// both stages empty. When rsp stalls, the output register holds its beat,
// the input register holds the next access and req drops ready once both
// are full; no beat is lost.
`default_nettype none

module masked_io_register_file
    import mior_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    mior_req_if.sink    req,
    mior_rsp_if.source  rsp
);

    logic              in_valid_reg;
    logic [CMD_W-1:0]  cmd_reg;
    logic [ADDR_W-1:0] addr_reg;
    logic [DATA_W-1:0] wval_reg;

    logic              out_valid_reg;
    logic [DATA_W-1:0] rdata_reg;
    logic [CODE_W-1:0] afault_reg;
    logic [CODE_W-1:0] sfault_reg;
    logic [CODE_W-1:0] sticky_reg;
    logic [CODE_W-1:0] sticky_next;

    acc_t              acc;
    logic [DATA_W-1:0] bank_rdata;
    logic              advance;

    assign advance   = in_valid_reg && (!out_valid_reg || rsp.ready);
    assign req.ready = !in_valid_reg || advance;

    mior_decode u_decode (
        .command (cmd_reg),
        .address (addr_reg),
        .acc     (acc)
    );

    mior_regs u_regs (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (advance),
        .acc         (acc),
        .write_value (wval_reg),
        .read_data   (bank_rdata)
    );

    assign sticky_next = (acc.fault != FAULT_NONE) ? acc.fault : sticky_reg;

    // input stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (req.ready)
        begin
            in_valid_reg <= req.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            cmd_reg  <= req.command;
            addr_reg <= req.address;
            wval_reg <= req.write_value;
        end
    end

    // result stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            sticky_reg    <= FAULT_NONE;
        end
        else
        begin
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                sticky_reg    <= sticky_next;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            rdata_reg  <= bank_rdata;
            afault_reg <= acc.fault;
            sfault_reg <= sticky_next;
        end
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.read_data    = rdata_reg;
    assign rsp.access_fault = afault_reg;
    assign rsp.sticky_fault = sfault_reg;

    a_sticky_records: assert property (@(posedge clk) disable iff (!rst_n)
        advance && acc.fault != FAULT_NONE |=> sticky_reg == $past(acc.fault))
        else $error("sticky fault not recorded");

    a_fault_zero_data: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.access_fault != FAULT_NONE |-> rsp.read_data == 8'h00)
        else $error("faulted access returned data");

    a_fault_matches_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.access_fault != FAULT_NONE |-> rsp.sticky_fault == rsp.access_fault)
        else $error("sticky fault differs from this beat's fault");

    a_input_held: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !advance |=> in_valid_reg)
        else $error("pending access dropped");

endmodule

`default_nettype wire
